// ----- src/rhs_pkg.sv -----
`timescale 1ns / 1ps

package rhs_pkg;

   localparam int MAX_SERVERS = 256;
   localparam int POS_W       = $clog2(MAX_SERVERS) + 1;
   localparam int IDX_W       = $clog2(MAX_SERVERS);
   localparam int RANK_BYTES  = 4;
   localparam int CNT_W       = $clog2(RANK_BYTES);

   localparam logic [63:0] FNV_BASIS   = 64'hcbf29ce484222325;
   // multiplier 0x100000001b3 = 2**40 + 0x1b3
   localparam int          FNV_SHIFT   = 40;
   localparam logic [8:0]  FNV_MULT_LO = 9'h1b3;

   typedef enum logic [2:0] {
      KIND_PATH_BYTE  = 3'd0,
      KIND_PATH_END   = 3'd1,
      KIND_UUID_BYTE  = 3'd2,
      KIND_RANK       = 3'd3,
      KIND_ADDR_BYTE  = 3'd4,
      KIND_SERVER_END = 3'd5,
      KIND_FINISH     = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      OP_ZERO = 2'd0,
      OP_CHAR = 2'd1,
      OP_RANK = 2'd2
   } opsel_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_RANK = 2'd1,
      ST_TAIL = 2'd2
   } state_type;

   typedef struct packed {
      logic      step;
      opsel_type opsel;
      logic      load_rank;
      logic      save_prefix;
      logic      server_end;
      logic      finish;
   } cmd_type;

endpackage

// ----- src/rhs_ctrl.sv -----
`timescale 1ns / 1ps

module rhs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  rhs_pkg::kind_type req_kind,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output rhs_pkg::cmd_type  cmd
);
   import rhs_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   // beyond a rank item's hold, a finish item waits only while an earlier result is still held
   assign req_tready = (state_ff == ST_IDLE) &&
                       (!rsp_valid_ff || rsp_tready || (req_kind != KIND_FINISH));
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      cmd.opsel    = OP_ZERO;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_PATH_BYTE, KIND_UUID_BYTE, KIND_ADDR_BYTE: begin
                     cmd.step  = 1'b1;
                     cmd.opsel = OP_CHAR;
                  end
                  KIND_PATH_END: begin
                     cmd.step        = 1'b1;
                     cmd.save_prefix = 1'b1;
                  end
                  KIND_RANK: begin
                     // leading NUL step now, then four rank bytes and a NUL
                     cmd.step      = 1'b1;
                     cmd.load_rank = 1'b1;
                     cnt_in        = '0;
                     state_in      = ST_RANK;
                  end
                  KIND_SERVER_END: begin
                     cmd.server_end = 1'b1;
                  end
                  KIND_FINISH: begin
                     cmd.finish   = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RANK: begin
            cmd.step  = 1'b1;
            cmd.opsel = OP_RANK;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(RANK_BYTES - 1)) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            cmd.step = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/rhs_datapath.sv -----
`timescale 1ns / 1ps

module rhs_datapath (
   input  logic             clock,
   input  logic             reset,
   input  rhs_pkg::cmd_type cmd,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   input  logic [7:0]       data_byte,
   input  logic [31:0]      rank_value,
   input  logic             server_live,
   output logic             found,
   output logic [7:0]       server_index,
   output logic [63:0]      win_score,
   output logic             index_overflow
);
   import rhs_pkg::*;

   logic             sign_ext_ff;
   logic [63:0]      running_ff, running_in;
   logic [63:0]      prefix_ff, prefix_in;
   logic [63:0]      best_ff, best_in;
   logic [IDX_W-1:0] best_pos_ff, best_pos_in;
   logic             have_best_ff, have_best_in;
   logic [POS_W-1:0] srv_pos_ff, srv_pos_in;
   logic             ovf_ff, ovf_in;
   logic [31:0]      rank_ff;

   logic [63:0] operand;
   logic [63:0] mix;
   logic [72:0] prod_lo;
   logic [63:0] stepped;
   logic        full;
   logic        take;

   always_comb begin
      case (cmd.opsel)
         OP_CHAR: operand = {{56{sign_ext_ff & data_byte[7]}}, data_byte};
         OP_RANK: operand = {56'd0, rank_ff[7:0]};
         default: operand = '0;
      endcase
   end

   // h * 0x100000001b3 mod 2**64 as (h << 40) + h * 0x1b3
   assign mix     = running_ff ^ operand;
   assign prod_lo = mix * FNV_MULT_LO;
   assign stepped = (mix << FNV_SHIFT) + prod_lo[63:0];

   assign full = srv_pos_ff >= POS_W'(MAX_SERVERS);
   assign take = server_live && (!have_best_ff || (running_ff > best_ff));

   always_comb begin
      running_in   = running_ff;
      prefix_in    = prefix_ff;
      best_in      = best_ff;
      best_pos_in  = best_pos_ff;
      have_best_in = have_best_ff;
      srv_pos_in   = srv_pos_ff;
      ovf_in       = ovf_ff;
      if (cmd.finish) begin
         running_in   = FNV_BASIS;
         prefix_in    = FNV_BASIS;
         best_in      = '0;
         best_pos_in  = '0;
         have_best_in = 1'b0;
         srv_pos_in   = '0;
         ovf_in       = 1'b0;
      end else if (cmd.server_end) begin
         running_in = prefix_ff;
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            if (take) begin
               best_in      = running_ff;
               best_pos_in  = srv_pos_ff[IDX_W-1:0];
               have_best_in = 1'b1;
            end
            srv_pos_in = srv_pos_ff + 1'b1;
         end
      end else if (cmd.step) begin
         running_in = stepped;
         if (cmd.save_prefix) begin
            prefix_in = stepped;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sign_ext_ff  <= 1'b1;
         running_ff   <= FNV_BASIS;
         prefix_ff    <= FNV_BASIS;
         best_ff      <= '0;
         best_pos_ff  <= '0;
         have_best_ff <= 1'b0;
         srv_pos_ff   <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            sign_ext_ff <= csr_wr_data;
         end
         running_ff   <= running_in;
         prefix_ff    <= prefix_in;
         best_ff      <= best_in;
         best_pos_ff  <= best_pos_in;
         have_best_ff <= have_best_in;
         srv_pos_ff   <= srv_pos_in;
         ovf_ff       <= ovf_in;
      end
   end

   // rank bytes go out low byte first
   always_ff @(posedge clock) begin
      if (cmd.load_rank) begin
         rank_ff <= rank_value;
      end else if (cmd.step && (cmd.opsel == OP_RANK)) begin
         rank_ff <= rank_ff >> 8;
      end
   end

   // result register, loaded from the state that finish is about to clear
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         found          <= have_best_ff;
         server_index   <= have_best_ff ? 8'(best_pos_ff) : 8'd0;
         win_score      <= have_best_ff ? best_ff : 64'd0;
         index_overflow <= ovf_ff;
      end
   end

endmodule

// ----- src/rendezvous_hash_server_select.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Ports                                  Contents
// req      in         req_tvalid/tready/tdata[47:0]/tuser[2:0]  one request item
// rsp      out        rsp_tvalid/tready/tdata[79:0]          chosen server on finish
// csr      in         csr_wr_en, csr_wr_data                 char sign-extend bit
//
// Byte and path end items each make one hash step; a rank item makes a NUL step,
// four rank byte steps and a NUL step, all through the single FNV multiply-add unit.
// Synchronous active-high reset; sign-extend resets to 1, hash state to basis.
// Beyond the hold during a rank item, a finish item stalls only while the previous
// result is still held in rsp; other items keep flowing while it waits.

module rendezvous_hash_server_select (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] data_byte, [39:8] rank_value, [40] server_live, [47:41] zero
   input  logic [47:0] req_tdata,
   // [2:0] req_type
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] found, [8:1] server_index, [72:9] win_score, [73] index_overflow,
   // [79:74] zero
   output logic [79:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import rhs_pkg::*;

   cmd_type     cmd;
   kind_type    req_kind;
   logic        found;
   logic [7:0]  server_index;
   logic [63:0] win_score;
   logic        index_overflow;

   assign req_kind = kind_type'(req_tuser);

   rhs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_kind),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   rhs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .data_byte      (req_tdata[7:0]),
      .rank_value     (req_tdata[39:8]),
      .server_live    (req_tdata[40]),
      .found          (found),
      .server_index   (server_index),
      .win_score      (win_score),
      .index_overflow (index_overflow)
   );

   assign rsp_tdata = {6'd0, index_overflow, win_score, server_index, found};

   a_rank_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == KIND_RANK)) |=>
         !req_tready ##1 !req_tready ##1 !req_tready ##1 !req_tready ##1 !req_tready)
      else $error("rank item did not hold the input for its hash steps");

   a_finish_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == KIND_FINISH)) |=> rsp_tvalid)
      else $error("finish item gave no result");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[72:1] == 72'd0))
      else $error("not-found result carries a nonzero index or score");

   a_one_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !(req_tready && (req_tuser == KIND_FINISH)))
      else $error("finish accepted while a result is still held");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import rhs_pkg::*;

   localparam logic [63:0] HASH_MULT    = 64'h100000001b3;
   localparam logic [2:0]  KIND_UNUSED  = 3'd7;
   localparam int          STALL_LIMIT  = 2000;
   localparam int          DRAIN_CYCLES = 12;

   typedef struct {
      logic        found;
      logic [7:0]  index;
      logic [63:0] score;
      logic        overflow;
   } pick_type;

   // Tracks the hash state of the request in flight and the server picks it owes.
   class server_pick_board;
      logic        sign_ext;
      logic [63:0] prefix_state;
      logic [63:0] hash_now;
      logic [63:0] top_score;
      logic [7:0]  top_index;
      logic        have_top;
      int unsigned slot;
      logic        slots_overflowed;
      pick_type    pending_picks[$];
      int          errors;
      int          items_seen;
      int          picks_seen;
      int          found_picks;
      int          overflow_picks;

      function new();
         sign_ext = 1'b1;
         errors = 0;
         items_seen = 0;
         picks_seen = 0;
         found_picks = 0;
         overflow_picks = 0;
         restart();
      endfunction

      function void restart();
         prefix_state = FNV_BASIS;
         hash_now = FNV_BASIS;
         top_score = '0;
         top_index = '0;
         have_top = 1'b0;
         slot = 0;
         slots_overflowed = 1'b0;
      endfunction

      function logic [63:0] fnv_mix(logic [63:0] h, logic [63:0] v);
         return (h ^ v) * HASH_MULT;
      endfunction

      function logic [63:0] char_value(logic [7:0] ch);
         if (sign_ext && ch[7])
            return {56'hff_ffff_ffff_ffff, ch};
         return {56'd0, ch};
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         errors++;
      endtask

      function void note_item(logic [2:0] kind, logic [7:0] ch, logic [31:0] rank,
                              logic live);
         pick_type p;
         int       b;
         items_seen++;
         case (kind)
            KIND_PATH_BYTE, KIND_UUID_BYTE, KIND_ADDR_BYTE: begin
               hash_now = fnv_mix(hash_now, char_value(ch));
            end
            KIND_PATH_END: begin
               hash_now = fnv_mix(hash_now, 64'd0);
               prefix_state = hash_now;
            end
            KIND_RANK: begin
               // NUL, four little-endian rank bytes (never extended), NUL
               hash_now = fnv_mix(hash_now, 64'd0);
               for (b = 0; b < 4; b++)
                  hash_now = fnv_mix(hash_now, {56'd0, rank[8*b +: 8]});
               hash_now = fnv_mix(hash_now, 64'd0);
            end
            KIND_SERVER_END: begin
               if (slot >= MAX_SERVERS) begin
                  slots_overflowed = 1'b1;
               end else begin
                  if (live && (!have_top || hash_now > top_score)) begin
                     top_score = hash_now;
                     top_index = slot[7:0];
                     have_top = 1'b1;
                  end
                  slot++;
               end
               hash_now = prefix_state;
            end
            KIND_FINISH: begin
               p.found = have_top;
               p.index = have_top ? top_index : 8'd0;
               p.score = have_top ? top_score : 64'd0;
               p.overflow = slots_overflowed;
               pending_picks.insert(pending_picks.size(), p);
               restart();
            end
            default: ;
         endcase
      endfunction

      task check_pick(logic [79:0] word);
         pick_type want;
         pick_type got;
         got.found = word[0];
         got.index = word[8:1];
         got.score = word[72:9];
         got.overflow = word[73];
         if (pending_picks.size() == 0) begin
            report($sformatf("result with nothing pending: %h", word));
            return;
         end
         want = pending_picks.pop_front();
         picks_seen++;
         if (want.found) found_picks++;
         if (want.overflow) overflow_picks++;
         if (got.found !== want.found)
            report($sformatf("found %b, want %b", got.found, want.found));
         if (got.index !== want.index)
            report($sformatf("server_index %0d, want %0d", got.index, want.index));
         if (got.score !== want.score)
            report($sformatf("win score %h, want %h", got.score, want.score));
         if (got.overflow !== want.overflow)
            report($sformatf("index_overflow %b, want %b", got.overflow, want.overflow));
         if (word[79:74] !== 6'd0)
            report($sformatf("padding bits %b not zero", word[79:74]));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   logic        csr_wr_en;
   logic        csr_wr_data;

   server_pick_board board;
   int send_idle_pct;
   int recv_idle_pct;
   int items_sent;
   int finishes_sent;
   int stall_cycles;

   rendezvous_hash_server_select dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         board.note_item(req_tuser, req_tdata[7:0], req_tdata[39:8], req_tdata[40]);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_pick(rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("** rendezvous_hash_server_select: FAILED **");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(logic [2:0] kind, logic [7:0] ch, logic [31:0] rank,
                            logic live);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'd0, live, rank, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      items_sent++;
      if (kind == KIND_FINISH) finishes_sent++;
   endtask

   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 8'($urandom_range(32, 126));
         4, 5:       return 8'($urandom_range(128, 255));
         default:    return 8'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_rank();
      case ($urandom_range(0, 7))
         0:       return 32'd0;
         1:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_bytes(logic [2:0] kind, int count);
      int i;
      for (i = 0; i < count; i++)
         send_item(kind, pick_char(), $urandom, 1'($urandom));
   endtask

   // Path, optional path end, a few servers, then finish.
   task automatic send_request();
      int servers;
      int s;
      send_bytes(KIND_PATH_BYTE, $urandom_range(0, 4));
      if ($urandom_range(0, 9) != 0)
         send_item(KIND_PATH_END, 8'($urandom), $urandom, 1'($urandom));
      servers = $urandom_range(0, 4);
      for (s = 0; s < servers; s++) begin
         send_bytes(KIND_UUID_BYTE, $urandom_range(0, 3));
         if ($urandom_range(0, 9) != 0)
            send_item(KIND_RANK, 8'($urandom), pick_rank(), 1'($urandom));
         send_bytes(KIND_ADDR_BYTE, $urandom_range(0, 3));
         send_item(KIND_SERVER_END, 8'($urandom), $urandom, $urandom_range(0, 3) != 0);
      end
      send_item(KIND_FINISH, 8'($urandom), $urandom, 1'($urandom));
   endtask

   task automatic send_noise();
      int n;
      int i;
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++)
         send_item(3'($urandom_range(0, 7)), 8'($urandom), $urandom, 1'($urandom));
      send_item(KIND_FINISH, 8'($urandom), $urandom, 1'($urandom));
   endtask

   // Only slot 255 is live below capacity, so it wins; live slots past it are ignored.
   task automatic send_overflow_request();
      int total;
      int s;
      send_bytes(KIND_PATH_BYTE, 2);
      send_item(KIND_PATH_END, 8'($urandom), $urandom, 1'($urandom));
      total = MAX_SERVERS + $urandom_range(1, 5);
      for (s = 0; s < total; s++)
         send_item(KIND_SERVER_END, 8'($urandom), $urandom,
                   s == MAX_SERVERS - 1 || (s >= MAX_SERVERS && 1'($urandom)));
      send_item(KIND_FINISH, 8'($urandom), $urandom, 1'($urandom));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending_picks.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_sign_extend(logic value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.sign_ext = value;
   endtask

   initial begin
      int phase;
      int start_items;
      int start_finishes;
      board = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      send_idle_pct = 12;
      recv_idle_pct = 49;
      items_sent = 0;
      finishes_sent = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: sign-extend at its reset value
      send_item(KIND_PATH_BYTE, 8'h41, 32'd0, 1'b0);
      send_item(KIND_PATH_BYTE, 8'hff, 32'hffff_ffff, 1'b1);
      send_item(KIND_PATH_BYTE, 8'h80, 32'd0, 1'b0);
      send_item(KIND_PATH_END, 8'h00, 32'd0, 1'b0);
      send_item(KIND_UUID_BYTE, 8'h00, 32'd0, 1'b0);
      send_item(KIND_UUID_BYTE, 8'hfe, 32'd0, 1'b0);
      send_item(KIND_RANK, 8'h00, 32'hffff_ffff, 1'b0);
      send_item(KIND_ADDR_BYTE, 8'h7f, 32'd0, 1'b0);
      send_item(KIND_SERVER_END, 8'h00, 32'd0, 1'b1);
      send_item(KIND_RANK, 8'hff, 32'd0, 1'b1);
      send_item(KIND_SERVER_END, 8'h00, 32'd0, 1'b1);
      send_item(KIND_SERVER_END, 8'h00, 32'd0, 1'b0);
      send_item(KIND_UNUSED, 8'hff, 32'hffff_ffff, 1'b1);
      send_item(KIND_FINISH, 8'h00, 32'd0, 1'b0);
      // empty request: nothing found
      send_item(KIND_FINISH, 8'hff, 32'hffff_ffff, 1'b1);
      // no path end: servers hash from the offset basis
      send_item(KIND_UUID_BYTE, 8'h81, 32'd0, 1'b0);
      send_item(KIND_SERVER_END, 8'h00, 32'd0, 1'b1);
      // path byte and path end after a server
      send_item(KIND_PATH_BYTE, 8'h20, 32'd0, 1'b0);
      send_item(KIND_PATH_END, 8'h00, 32'd0, 1'b0);
      send_item(KIND_ADDR_BYTE, 8'hc3, 32'd0, 1'b0);
      send_item(KIND_SERVER_END, 8'h00, 32'd0, 1'b0);
      send_item(KIND_SERVER_END, 8'h00, 32'd0, 1'b1);
      send_item(KIND_FINISH, 8'h00, 32'd0, 1'b0);

      for (phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0:       begin send_idle_pct = 12; recv_idle_pct = 49; end
            1:       begin send_idle_pct = 49; recv_idle_pct = 12; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         drain();
         write_sign_extend(phase % 2 != 0);
         start_items = items_sent;
         start_finishes = finishes_sent;
         if (phase == 2) send_overflow_request();
         while (items_sent - start_items < 50 || finishes_sent - start_finishes < 4) begin
            if ($urandom_range(0, 99) < 15)
               send_noise();
            else
               send_request();
         end
      end
      drain();

      $display("Sent %0d items; checked %0d results (%0d with a server, %0d overflowed).",
               board.items_seen, board.picks_seen, board.found_picks, board.overflow_picks);
      $display("Sign extension off and on, under three idling patterns on both channels.");
      if (board.errors == 0)
         $display("** rendezvous_hash_server_select: PASSED **");
      else
         $display("** rendezvous_hash_server_select: FAILED **");
      $finish;
   end

endmodule
